/* sv/rfrb_pkg.sv */
`timescale 1ns / 1ps
package rfrb_pkg;
	localparam int FRAME_SLOTS = 8;
	localparam int PKTS_PER_FRAME = 64;
	localparam int SLOT_W = $clog2(FRAME_SLOTS);
	localparam int POS_W = $clog2(PKTS_PER_FRAME);
	localparam int CNT_W = POS_W + 1;
	localparam int ADDR_W = SLOT_W + POS_W;
	localparam int FIU_W = 4;
	localparam int IN_W = 2 + 1 + 16 + 32 + 1 + 7 + 32 + 16 + 1;
	localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 3 + 32 + 16 + 16 + 7 + 32 + 32 * 4;
	localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_RESYNC = 2'd1;
	localparam logic [1:0] FN_COUNT = 2'd2;

	localparam logic [2:0] ST_BUFFERED = 3'd0;
	localparam logic [2:0] ST_EMIT = 3'd1;
	localparam logic [2:0] ST_NOSLOT = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BADHDR = 3'd4;
	localparam logic [2:0] ST_RESYNC = 3'd5;
	localparam logic [2:0] ST_COUNTED = 3'd6;

	typedef struct packed {
		logic [15:0] seq;
		logic [31:0] handle;
		logic [15:0] len;
	} entry_t;

	typedef struct packed {
		logic        we;
		logic [ADDR_W-1:0] waddr;
		entry_t      wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;
endpackage

/* sv/rfrb_entry_ram.sv */
`timescale 1ns / 1ps
module rfrb_entry_ram (
	input  logic              clk,
	input  rfrb_pkg::mem_req_t req,
	output rfrb_pkg::entry_t   rdata
);
	import rfrb_pkg::*;

	entry_t mem [FRAME_SLOTS*PKTS_PER_FRAME];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

/* sv/rfrb_ctrl.sv */
`timescale 1ns / 1ps
module rfrb_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rfrb_pkg::FIU_W-1:0] fiu,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rfrb_pkg::IN_W-1:0]  in_bits,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rfrb_pkg::OUT_W-1:0] out_bits,
	output logic                       out_last,
	output rfrb_pkg::mem_req_t         req,
	input  rfrb_pkg::entry_t           rdata
);
	import rfrb_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DEC   = 9'b000000010,
		S_OLD   = 9'b000000100,
		S_FIND  = 9'b000001000,
		S_SHIFT = 9'b000010000,
		S_PICK  = 9'b000100000,
		S_CHK   = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [1:0]  func_q;
	logic        hok_q, mark_q, rel_q;
	logic [15:0] seq_q, len_q;
	logic [31:0] ts_q, hdl_q;
	logic [6:0]  pt_q;

	logic [FRAME_SLOTS-1:0] sv_q;
	logic [31:0] sts_q [FRAME_SLOTS];
	logic [6:0]  spt_q [FRAME_SLOTS];
	logic [FRAME_SLOTS-1:0] smk_q;
	logic [CNT_W-1:0] scnt_q [FRAME_SLOTS];

	logic [15:0] exp_q;
	logic [31:0] lost_q, drop_q, dis_q, tot_q;

	logic [SLOT_W-1:0] slot_q, old_q;
	logic              old_ok_q;
	logic [SLOT_W:0]   si_q;
	logic [CNT_W-1:0]  i_q, n_q;
	logic              rd_pend_q;
	logic [15:0]       want_q;

	logic [2:0]  o_st_q;
	logic        o_last_q;
	entry_t      o_ent_q;
	logic [6:0]  o_pt_q;
	logic [31:0] o_ts_q;
	logic        out_v_q;
	logic        out_load;

	logic [FIU_W-1:0] lim;
	logic [3:0]       used;
	logic             hit;
	logic [SLOT_W-1:0] hit_s, free_s;
	logic             free_ok;

	always_comb begin
		lim = fiu;
		if (lim == '0) lim = FIU_W'(1);
		if (lim > FIU_W'(FRAME_SLOTS)) lim = FIU_W'(FRAME_SLOTS);
		used = '0;
		hit = 1'b0;
		hit_s = '0;
		free_ok = 1'b0;
		free_s = '0;
		for (int s = 0; s < FRAME_SLOTS; s++) begin
			if (sv_q[s]) begin
				used = used + 4'd1;
				if (sts_q[s] == ts_q) begin
					hit = 1'b1;
					hit_s = SLOT_W'(s);
				end
			end
		end
		for (int s = FRAME_SLOTS - 1; s >= 0; s--) begin
			if (!sv_q[s]) begin
				free_ok = 1'b1;
				free_s = SLOT_W'(s);
			end
		end
	end

	assign in_ready = (state_q == S_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_load = (!out_v_q || out_ready) &&
		((state_q == S_EMIT && rd_pend_q) || state_q == S_OUT);
	assign out_last = o_last_q;
	assign out_bits = {tot_q, dis_q, drop_q, lost_q, o_ts_q, o_pt_q,
		o_ent_q.seq, o_ent_q.len, o_ent_q.handle, o_st_q};

	logic [CNT_W-1:0] n_cur;
	assign n_cur = scnt_q[slot_q];

	always_comb begin
		req = '0;
		req.raddr = {old_q, i_q[POS_W-1:0]};
		unique case (state_q)
			S_FIND: req.raddr = {slot_q, i_q[POS_W-1:0]};
			S_SHIFT: begin
				req.raddr = {slot_q, POS_W'(n_q - CNT_W'(1))};
				if (rd_pend_q) begin
					req.we = 1'b1;
					req.waddr = {slot_q, n_q[POS_W-1:0]};
					req.wdata = rdata;
				end
			end
			S_PICK: begin
				req.we = 1'b1;
				req.waddr = {slot_q, i_q[POS_W-1:0]};
				req.wdata = '{seq: seq_q, handle: hdl_q, len: len_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sv_q <= '0;
			for (int s = 0; s < FRAME_SLOTS; s++) scnt_q[s] <= '0;
			exp_q <= '0;
			lost_q <= '0;
			drop_q <= '0;
			dis_q <= '0;
			tot_q <= '0;
			out_v_q <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !out_v_q) begin
						{rel_q, len_q, hdl_q, pt_q, mark_q, ts_q, seq_q, hok_q, func_q} <= in_bits;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					o_ent_q <= '0;
					o_pt_q <= '0;
					o_ts_q <= '0;
					o_last_q <= 1'b1;
					if (func_q == FN_RESYNC) begin
						exp_q <= seq_q;
						if (rel_q) lost_q <= lost_q + 32'd1;
						o_st_q <= ST_RESYNC;
						state_q <= S_OUT;
					end else if (func_q == FN_COUNT) begin
						tot_q <= tot_q + 32'd1;
						o_st_q <= ST_COUNTED;
						state_q <= S_OUT;
					end else if (func_q != FN_INSERT) begin
						state_q <= S_IDLE;
					end else if (!hok_q) begin
						o_st_q <= ST_BADHDR;
						state_q <= S_OUT;
					end else begin
						if ({16'd0, seq_q} == {16'd0, exp_q} + 32'd1) begin
							exp_q <= seq_q;
						end else if ({16'd0, seq_q} > {16'd0, exp_q} + 32'd1) begin
							dis_q <= dis_q + 32'd1;
							lost_q <= lost_q + ({16'd0, seq_q} - {16'd0, exp_q} - 32'd1);
							exp_q <= seq_q;
						end else begin
							dis_q <= dis_q + 32'd1;
							lost_q <= lost_q - ({16'd0, exp_q} - {16'd0, seq_q} - 32'd1);
						end
						if (hit) begin
							slot_q <= hit_s;
							if (!smk_q[hit_s]) smk_q[hit_s] <= mark_q;
							if (scnt_q[hit_s] == CNT_W'(PKTS_PER_FRAME)) begin
								o_st_q <= ST_FULL;
								state_q <= S_OUT;
							end else begin
								i_q <= '0;
								state_q <= S_FIND;
							end
						end else if (used < 4'(lim) && free_ok) begin
							slot_q <= free_s;
							sv_q[free_s] <= 1'b1;
							sts_q[free_s] <= ts_q;
							spt_q[free_s] <= pt_q;
							smk_q[free_s] <= mark_q;
							scnt_q[free_s] <= '0;
							i_q <= '0;
							state_q <= S_FIND;
						end else begin
							o_st_q <= ST_NOSLOT;
							si_q <= '0;
							old_ok_q <= 1'b0;
							state_q <= S_OLD;
						end
					end
				end
				S_OLD: begin
					if (si_q == (SLOT_W+1)'(FRAME_SLOTS)) begin
						if (old_ok_q) begin
							lost_q <= lost_q + 32'(scnt_q[old_q]);
							drop_q <= drop_q + 32'd1;
							sv_q[old_q] <= 1'b0;
							scnt_q[old_q] <= '0;
						end
						state_q <= S_OUT;
					end else begin
						if (sv_q[si_q[SLOT_W-1:0]] &&
						    (!old_ok_q || sts_q[si_q[SLOT_W-1:0]] < sts_q[old_q])) begin
							old_ok_q <= 1'b1;
							old_q <= si_q[SLOT_W-1:0];
						end
						si_q <= si_q + 1'b1;
					end
				end
				S_FIND: begin
					// Linear scan: read entry i, compare next cycle.
					if (!rd_pend_q) begin
						if (i_q == n_cur) begin
							n_q <= n_cur;
							state_q <= S_SHIFT;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else begin
						rd_pend_q <= 1'b0;
						if (seq_q > rdata.seq) begin
							i_q <= i_q + 1'b1;
						end else begin
							n_q <= n_cur;
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					// Moves entries up from n down to i; n_q walks downward.
					if (!rd_pend_q) begin
						if (n_q == i_q) begin
							state_q <= S_PICK;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else begin
						rd_pend_q <= 1'b0;
						n_q <= n_q - 1'b1;
					end
				end
				S_PICK: begin
					scnt_q[slot_q] <= n_cur + 1'b1;
					si_q <= '0;
					old_ok_q <= 1'b0;
					state_q <= S_CHK;
					i_q <= '1;
				end
				S_CHK: begin
					if (&i_q) begin
						if (si_q == (SLOT_W+1)'(FRAME_SLOTS)) begin
							if (old_ok_q && scnt_q[old_q] != '0 && smk_q[old_q]) begin
								i_q <= '0;
								rd_pend_q <= 1'b0;
							end else begin
								o_st_q <= ST_BUFFERED;
								state_q <= S_OUT;
							end
						end else begin
							if (sv_q[si_q[SLOT_W-1:0]] &&
							    (!old_ok_q || sts_q[si_q[SLOT_W-1:0]] < sts_q[old_q])) begin
								old_ok_q <= 1'b1;
								old_q <= si_q[SLOT_W-1:0];
							end
							si_q <= si_q + 1'b1;
						end
					end else if (!rd_pend_q) begin
						if (i_q == scnt_q[old_q]) begin
							i_q <= '0;
							state_q <= S_EMIT;
						end else begin
							rd_pend_q <= 1'b1;
						end
					end else begin
						rd_pend_q <= 1'b0;
						if (i_q != '0 && rdata.seq != want_q) begin
							o_st_q <= ST_BUFFERED;
							state_q <= S_OUT;
						end else begin
							want_q <= rdata.seq + 16'd1;
							i_q <= i_q + 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (!rd_pend_q) begin
						if (!out_v_q || out_ready) rd_pend_q <= 1'b1;
					end else if (out_load) begin
						rd_pend_q <= 1'b0;
						o_st_q <= ST_EMIT;
						o_ent_q <= rdata;
						o_pt_q <= spt_q[old_q];
						o_ts_q <= sts_q[old_q];
						o_last_q <= (i_q + 1'b1 == scnt_q[old_q]);
						if (i_q + 1'b1 == scnt_q[old_q]) begin
							sv_q[old_q] <= 1'b0;
							scnt_q[old_q] <= '0;
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/rtp_frame_reorder_buffer.sv */
`timescale 1ns / 1ps
// RTP frame reorder buffer.
// The slave stream carries packet descriptors and commands; the master
// stream carries result beats, with tlast on the final beat of a run.
// One beat is taken at a time: a resync or count command is answered with a
// single result beat; an insert takes a linear search and shift over the
// slot entries in the entry memory, followed by an oldest-frame scan of the
// slot table and, for a finished frame, a contiguity pass and one result
// beat per packet. The entry memory has one read and one write port.
// After reset all slots are empty, counters are zero and frames_in_use is 8.
// The entry memory is not cleared; only written entries are ever read.
// A stalled receiver holds the result register; the block then waits and
// accepts no new slave beat until the run is delivered.
module rtp_frame_reorder_buffer (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [rfrb_pkg::FIU_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	// func, header_ok, seq, timestamp, marker, payload_type, buf_handle, pkt_len, release_flag
	input  logic [rfrb_pkg::IN_BYTES_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// status, out_handle, out_len, out_seq, out_payload_type, out_timestamp,
	// lost_packets, lost_frames, disorder_count, total_packets
	output logic [rfrb_pkg::OUT_BYTES_W-1:0] m_tdata,
	output logic m_tlast
);
	import rfrb_pkg::*;

	logic [FIU_W-1:0] fiu_q;
	mem_req_t req;
	entry_t rdata;
	logic [OUT_W-1:0] ob;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_W'(8);
		end else if (cfg_we) begin
			fiu_q <= cfg_wdata;
		end
	end

	rfrb_entry_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

	rfrb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .fiu(fiu_q),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_bits(s_tdata[IN_W-1:0]),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_bits(ob),
		.out_last(m_tlast),
		.req(req), .rdata(rdata)
	);

	assign m_tdata = OUT_BYTES_W'(ob);
endmodule

/* sv/rfrb_checker.sv */
`timescale 1ns / 1ps
module rfrb_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tlast,
	input logic [rfrb_pkg::OUT_BYTES_W-1:0] m_tdata
);
	import rfrb_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled beat changed");
	a_noready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted two beats back to back");
	a_lastst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[2:0] == ST_EMIT)
		else $error("non-final beat is not an emission");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= ST_COUNTED)
		else $error("bad status");
endmodule

bind rtp_frame_reorder_buffer rfrb_checker u_chk (.*);
